// ===== design/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// Used by lr_ctrl, lr_datapath and line_rasterizer; no dependencies.
package lr_pkg;

  // Screen and coordinate sizes
  localparam int SCREEN_MAX = 64;
  localparam int COORD_BITS = 12;
  localparam int CW         = COORD_BITS + 1;        // walk coordinate width
  localparam int ERR_W      = COORD_BITS + 3;        // decision error width
  localparam int DIM_W      = 7;                     // screen size register width
  localparam int PIX_W      = $clog2(SCREEN_MAX);    // output pixel coordinate width

  // Configuration register indexes (paddr[2])
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Walk kinds
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_VERTICAL   = 3'd1,
    MODE_HORIZONTAL = 3'd2,
    MODE_SHALLOW    = 3'd3,
    MODE_STEEP      = 3'd4
  } draw_mode_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_SETUP,
    ST_WALK,
    ST_FINISH
  } lr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture endpoints
    logic order;   // sort endpoints by y, form differences
    logic setup;   // pick walk kind, load walk registers
    logic step;    // advance walk by one coordinate
    logic finish;  // push held pixel (or the empty marker) as the last word
  } lr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;      // no further pixel can come from the walk
    logic stall;     // a pixel is found but nowhere to put it
    logic out_free;  // output register can take a word this cycle
  } lr_status_t;

  // Screen size limited to the largest supported screen
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v > DIM_W'(SCREEN_MAX)) begin
      return DIM_W'(SCREEN_MAX);
    end
    return v;
  endfunction

endpackage

// ===== design/line_rasterizer.sv =====
// Line rasterizer top level: stream ports, screen size registers, controller
// and datapath. Depends on lr_pkg, lr_ctrl and lr_datapath.
//
// Usage
//   s_* takes one line segment per word (two signed 12-bit endpoints).
//   m_* returns the visible pixels of that segment in drawing order; tlast
//   marks the final word of a segment. A segment with no visible pixel
//   returns a single word with tuser (pixel present) low and tlast high.
//   screen_width / screen_height sit at byte addresses 0 and 4 of the APB
//   port; both reset to 64, values above 64 act as 64. Write only when idle.
// Timing
//   A segment is captured, sorted and set up, then walked one coordinate per
//   cycle while the walk is not stalled until the walk ends, then the last
//   word is flushed. The walk covers at most the segment's major-axis span
//   (up to 4095) and ends early once it leaves the screen. A word appears on
//   m_* the cycle after the walk reaches the next visible pixel; a one-pixel
//   hold stage lets tlast be known in advance. s_tready is high only between
//   segments.
// Reset and stalls
//   rst (synchronous) empties the block and restores the screen size.
//   A stalled receiver freezes the walk only when a found pixel has neither
//   the hold stage nor the output register free.
module line_rasterizer
  import lr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pixel_x[5:0], pixel_y[11:6], zero[15:12]
  output logic [0:0]  m_tuser,   // pixel_valid[0]
  output logic        m_tlast,   // last_pixel
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_W-1:0] screen_width, screen_height;
  lr_cmd_t          cmd;
  lr_status_t       status;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic             pixel_valid;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(SCREEN_MAX);
      screen_height <= DIM_W'(SCREEN_MAX);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, screen_width};
      REG_SCREEN_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, screen_height};
      default:           prdata = '0;
    endcase
  end

  lr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .start_x       (s_tdata[11:0]),
    .start_y       (s_tdata[23:12]),
    .end_x         (s_tdata[35:24]),
    .end_y         (s_tdata[47:36]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_valid   (pixel_valid),
    .last_pixel    (m_tlast)
  );

  // Output packing
  assign m_tdata = {4'b0000, pixel_y, pixel_x};
  assign m_tuser = pixel_valid;

endmodule

// ===== design/lr_ctrl.sv =====
// Line rasterizer controller: sequences capture, ordering, setup, walk, finish.
// Depends on lr_pkg.
module lr_ctrl
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lr_status_t status,
  output lr_cmd_t    cmd
);

  lr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ORDER;
        end
      end
      ST_ORDER:  state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_WALK;
      ST_WALK: begin
        if (status.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs; no word is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_ORDER:  cmd.order = 1'b1;
      ST_SETUP:  cmd.setup = 1'b1;
      ST_WALK:   cmd.step = !status.done && !status.stall;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== design/lr_datapath.sv =====
// Line rasterizer datapath: endpoint registers, walk registers for the four line
// kinds, one-pixel hold stage and the output register. Depends on lr_pkg.
module lr_datapath
  import lr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lr_cmd_t                 cmd,
  output lr_status_t              status,
  input  logic [DIM_W-1:0]        screen_width,
  input  logic [DIM_W-1:0]        screen_height,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIX_W-1:0]        pixel_x,
  output logic [PIX_W-1:0]        pixel_y,
  output logic                    pixel_valid,
  output logic                    last_pixel
);

  // Captured / ordered endpoints
  logic signed [COORD_BITS-1:0] pt_sx, pt_sy, pt_ex, pt_ey;
  logic signed [CW-1:0]         diff_x, diff_y;
  logic                         is_vert, is_horiz;

  // Walk registers
  draw_mode_t              draw_mode;
  logic                    mirror_flag;
  logic signed [CW-1:0]    step_x, step_y, stop_coord;
  logic signed [ERR_W-1:0] decision_error, err_inc0, err_inc1;
  logic signed [1:0]       whole_step;

  // Hold stage and output register
  logic             pend_valid;
  logic [PIX_W-1:0] pend_x, pend_y;

  // Screen limits as signed walk-width values
  logic signed [CW-1:0] w_s, h_s;
  assign w_s = $signed({{(CW-DIM_W){1'b0}}, clamp_dim(screen_width)});
  assign h_s = $signed({{(CW-DIM_W){1'b0}}, clamp_dim(screen_height)});

  // ---- ordering stage: sort by y ----
  logic signed [CW-1:0] sx_e, sy_e, ex_e, ey_e, d0y;
  logic                 swap;
  assign sx_e = {pt_sx[COORD_BITS-1], pt_sx};
  assign sy_e = {pt_sy[COORD_BITS-1], pt_sy};
  assign ex_e = {pt_ex[COORD_BITS-1], pt_ex};
  assign ey_e = {pt_ey[COORD_BITS-1], pt_ey};
  assign d0y  = ey_e - sy_e;
  assign swap = d0y < 0;

  // ---- setup stage ----
  logic signed [CW-1:0]    adx, steep_r, mir_sx, mir_ex;
  logic signed [ERR_W-1:0] dy_e, adx_e, r_e;
  logic                    shallow, dx_neg, dx_eq_dy;
  logic                    vert_vis, horiz_vis;

  assign dx_neg   = diff_x < 0;
  assign adx      = dx_neg ? -diff_x : diff_x;
  assign shallow  = diff_y < adx;
  assign dx_eq_dy = diff_x == diff_y;
  assign dy_e     = $signed({{(ERR_W-CW){diff_y[CW-1]}}, diff_y});
  assign adx_e    = $signed({{(ERR_W-CW){adx[CW-1]}}, adx});
  // remainder of floor(dx/dy); |dx| <= dy here so the quotient is -1, 0 or 1
  assign steep_r  = dx_neg ? (diff_x + diff_y) : (dx_eq_dy ? '0 : diff_x);
  assign r_e      = $signed({{(ERR_W-CW){steep_r[CW-1]}}, steep_r});
  assign mir_sx   = w_s - sx_e;
  assign mir_ex   = w_s - ex_e;
  assign vert_vis  = (sx_e >= 0) && (sx_e < w_s);
  assign horiz_vis = (sy_e >= 0) && (sy_e < h_s);

  // ---- walk step ----
  logic                    hit, walk_done;
  logic [PIX_W-1:0]        hit_x, hit_y;
  logic signed [CW-1:0]    nx, ny, x_mir, steep_dx;
  logic signed [ERR_W-1:0] sh_err, st_e1, st_e2;
  logic                    sh_up, st_carry;

  // shallow: midpoint decision, pixel checked after the move
  assign sh_up  = decision_error > 0;
  assign nx     = step_x + CW'(1);
  assign ny     = sh_up ? step_y + CW'(1) : step_y;
  assign sh_err = sh_up ? decision_error + err_inc1 : decision_error + err_inc0;
  assign x_mir  = mirror_flag ? w_s - nx : nx;

  // steep: fraction accumulates, carry moves x one more column
  assign st_e1    = decision_error + err_inc0;
  assign st_e2    = decision_error + err_inc1;
  assign st_carry = st_e1 > 0;
  assign steep_dx = $signed({{(CW-2){whole_step[1]}}, whole_step}) +
                    $signed({{(CW-1){1'b0}}, st_carry});

  always_comb begin
    hit       = 1'b0;
    walk_done = 1'b1;
    hit_x     = step_x[PIX_W-1:0];
    hit_y     = step_y[PIX_W-1:0];
    unique case (draw_mode)
      MODE_VERTICAL: begin
        hit       = (step_y > 0) && (step_y < h_s);
        walk_done = (step_y >= stop_coord) || (step_y >= h_s);
      end
      MODE_HORIZONTAL: begin
        hit       = (step_x > 0) && (step_x < w_s);
        walk_done = (step_x >= stop_coord) || (step_x >= w_s);
      end
      MODE_SHALLOW: begin
        hit       = (nx > 0) && (nx < w_s) && (ny > 0) && (ny < h_s);
        walk_done = (step_x >= stop_coord) || (step_x >= w_s) || (step_y >= h_s);
        hit_x     = x_mir[PIX_W-1:0];
        hit_y     = ny[PIX_W-1:0];
      end
      MODE_STEEP: begin
        hit       = (step_y > 0) && (step_y < h_s) && (step_x > 0) && (step_x < w_s);
        walk_done = (step_y >= stop_coord) || (step_y >= h_s);
      end
      default: begin
        hit       = 1'b0;
        walk_done = 1'b1;
      end
    endcase
  end

  // Status
  logic out_busy;
  assign out_busy        = out_valid && !out_ready;
  assign status.done     = walk_done;
  assign status.stall    = hit && pend_valid && out_busy;
  assign status.out_free = !out_busy;

  // Endpoint capture and ordering
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_sx <= start_x;
      pt_sy <= start_y;
      pt_ex <= end_x;
      pt_ey <= end_y;
    end else if (cmd.order) begin
      if (swap) begin
        pt_sx <= pt_ex;
        pt_sy <= pt_ey;
        pt_ex <= pt_sx;
        pt_ey <= pt_sy;
      end
      diff_x   <= swap ? sx_e - ex_e : ex_e - sx_e;
      diff_y   <= swap ? -d0y : d0y;
      is_vert  <= pt_sx == pt_ex;
      is_horiz <= pt_sy == pt_ey;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode <= MODE_IDLE;
    end else if (cmd.setup) begin
      if (is_vert) begin
        draw_mode   <= vert_vis ? MODE_VERTICAL : MODE_IDLE;
        mirror_flag <= 1'b0;
        step_x      <= sx_e;
        step_y      <= sy_e;
        stop_coord  <= ey_e;
      end else if (is_horiz) begin
        draw_mode   <= horiz_vis ? MODE_HORIZONTAL : MODE_IDLE;
        mirror_flag <= 1'b0;
        step_x      <= dx_neg ? ex_e : sx_e;
        stop_coord  <= dx_neg ? sx_e : ex_e;
        step_y      <= sy_e;
      end else if (shallow) begin
        draw_mode      <= MODE_SHALLOW;
        mirror_flag    <= dx_neg;
        step_x         <= dx_neg ? mir_sx : sx_e;
        stop_coord     <= dx_neg ? mir_ex : ex_e;
        step_y         <= sy_e;
        decision_error <= (dy_e <<< 1) - adx_e;
        err_inc0       <= dy_e <<< 1;
        err_inc1       <= (dy_e - adx_e) <<< 1;
      end else begin
        draw_mode      <= MODE_STEEP;
        mirror_flag    <= 1'b0;
        step_x         <= sx_e;
        step_y         <= sy_e;
        stop_coord     <= ey_e;
        whole_step     <= dx_neg ? 2'sb11 : (dx_eq_dy ? 2'sb01 : 2'sb00);
        decision_error <= -dy_e;
        err_inc0       <= r_e <<< 1;
        err_inc1       <= (r_e - dy_e) <<< 1;
      end
    end else if (cmd.step) begin
      unique case (draw_mode)
        MODE_VERTICAL:   step_y <= step_y + CW'(1);
        MODE_HORIZONTAL: step_x <= step_x + CW'(1);
        MODE_SHALLOW: begin
          step_x         <= nx;
          step_y         <= ny;
          decision_error <= sh_err;
        end
        MODE_STEEP: begin
          step_y         <= step_y + CW'(1);
          step_x         <= step_x + steep_dx;
          decision_error <= st_carry ? st_e2 : st_e1;
        end
        default: ;
      endcase
    end else if (cmd.finish) begin
      draw_mode <= MODE_IDLE;
    end
  end

  // Hold stage: a pixel waits here until the next one shows it was not the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && hit) begin
      pend_valid <= 1'b1;
      pend_x     <= hit_x;
      pend_y     <= hit_y;
    end else if (cmd.finish) begin
      pend_valid <= 1'b0;
    end
  end

  // Output register; a new word is loaded only when the old one is gone or leaving
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && hit && pend_valid) begin
      out_valid   <= 1'b1;
      pixel_x     <= pend_x;
      pixel_y     <= pend_y;
      pixel_valid <= 1'b1;
      last_pixel  <= 1'b0;
    end else if (cmd.finish) begin
      out_valid   <= 1'b1;
      pixel_x     <= pend_valid ? pend_x : '0;
      pixel_y     <= pend_valid ? pend_y : '0;
      pixel_valid <= pend_valid;
      last_pixel  <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
